@@ sv/drc3_pkg.sv @@
package drc3_pkg;

    localparam int CoordW = 32;
    localparam int LimW   = 31;
    localparam int SqW    = 68;           // sum of three 33-bit squares
    localparam int RootW  = 35;           // root bits, one cell per bit
    localparam int MagW   = 33;           // magnitude of a displacement
    localparam int NumW   = MagW + LimW;  // magnitude times radius
    localparam int QuoW   = NumW - LimW + 1;
    localparam int DivSteps = QuoW;

    // APB byte address of the radius register
    localparam logic [1:0] RegLimitRadius = 2'd0;

    typedef struct packed {
        logic signed [CoordW-1:0] ox;
        logic signed [CoordW-1:0] oy;
        logic signed [CoordW-1:0] oz;
        logic signed [CoordW-1:0] mx;
        logic signed [CoordW-1:0] my;
        logic signed [CoordW-1:0] mz;
        logic [MagW-1:0]          ax;
        logic [MagW-1:0]          ay;
        logic [MagW-1:0]          az;
        logic                     clamp;
        logic [LimW-1:0]          lim;
    } drc3_item_t;

endpackage

@@ sv/drc3_sqrt_cell.sv @@
module drc3_sqrt_cell
    import drc3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [5:0]        bit_pos,
    input  logic              in_valid,
    input  logic [SqW-1:0]    in_rem,
    input  logic [RootW-1:0]  in_root,
    input  drc3_item_t        in_item,
    output logic              out_valid,
    output logic [SqW-1:0]    out_rem,
    output logic [RootW-1:0]  out_root,
    output drc3_item_t        out_item
);
    // Restoring square root step: rem holds S - root^2.
    logic [SqW+1:0] trial;
    logic [SqW-1:0] rem_next;
    logic [RootW-1:0] root_next;

    always_comb
    begin
        trial = ({2'b00, in_root} << (bit_pos + 6'd1))
              + ({{(SqW+1){1'b0}}, 1'b1} << (bit_pos*2));
        if (trial <= {2'b00, in_rem})
        begin
            rem_next  = in_rem - trial[SqW-1:0];
            root_next = in_root | (RootW'(1) << bit_pos);
        end
        else
        begin
            rem_next  = in_rem;
            root_next = in_root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        out_rem  <= rem_next;
        out_root <= root_next;
        out_item <= in_item;
    end
endmodule

@@ sv/drc3_div_cell.sv @@
module drc3_div_cell
    import drc3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [6:0]        bit_pos,
    input  logic              in_valid,
    input  logic [RootW-1:0]  den,
    input  logic [NumW-1:0]   in_rem [3],
    input  logic [QuoW-1:0]   in_quo [3],
    input  drc3_item_t        in_item,
    output logic              out_valid,
    output logic [RootW-1:0]  out_den,
    output logic [NumW-1:0]   out_rem [3],
    output logic [QuoW-1:0]   out_quo [3],
    output drc3_item_t        out_item
);
    // One restoring divide bit for each of the three lanes.
    logic [NumW-1:0] rem_next [3];
    logic [QuoW-1:0] quo_next [3];
    logic [NumW+RootW:0] sh;

    always_comb
    begin
        sh = '0;
        for (int k = 0; k < 3; k++)
        begin
            sh = {{(NumW+1){1'b0}}, den} << bit_pos;
            if (sh <= {{(RootW+1){1'b0}}, in_rem[k]})
            begin
                rem_next[k] = in_rem[k] - sh[NumW-1:0];
                quo_next[k] = in_quo[k] | (QuoW'(1) << bit_pos);
            end
            else
            begin
                rem_next[k] = in_rem[k];
                quo_next[k] = in_quo[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        out_den  <= den;
        out_rem  <= rem_next;
        out_quo  <= quo_next;
        out_item <= in_item;
    end
endmodule

@@ sv/displacement_radius_clamp_3d.sv @@
// Pipelined 3D displacement clamp. busy is tied low, so a point word is accepted at
// every clock edge where start is high, back to back with no gaps. Its result is on
// the held_* ports with done high for one cycle, after it passes through the
// pipeline of 2 input stages, 35 root cells (one per root bit of the
// 68-bit squared length), 34 divide cells (one per quotient bit of the scaled
// components) and the output register. The receiver cannot stall; take each result
// in the cycle that done is high. limit_radius is register 0 at byte address 0 of
// the APB port; write it only while no word is in flight.
module displacement_radius_clamp_3d
    import drc3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [CoordW-1:0] orig_x,
    input  logic signed [CoordW-1:0] orig_y,
    input  logic signed [CoordW-1:0] orig_z,
    input  logic signed [CoordW-1:0] moved_x,
    input  logic signed [CoordW-1:0] moved_y,
    input  logic signed [CoordW-1:0] moved_z,
    output logic                     done,
    output logic signed [CoordW-1:0] held_x,
    output logic signed [CoordW-1:0] held_y,
    output logic signed [CoordW-1:0] held_z,
    output logic                     was_clamped,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [1:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    logic [LimW-1:0] limit_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = (paddr == RegLimitRadius) ? {1'b0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (psel && penable && pwrite && paddr == RegLimitRadius)
            limit_reg <= pwdata[LimW-1:0];
    end

    // Stage A: displacements and magnitudes.
    logic a_valid_reg;
    drc3_item_t a_item_reg;
    logic signed [CoordW:0] dx, dy, dz;

    always_comb
    begin
        dx = moved_x - orig_x;
        dy = moved_y - orig_y;
        dz = moved_z - orig_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        a_item_reg.ox <= orig_x;
        a_item_reg.oy <= orig_y;
        a_item_reg.oz <= orig_z;
        a_item_reg.mx <= moved_x;
        a_item_reg.my <= moved_y;
        a_item_reg.mz <= moved_z;
        a_item_reg.ax <= dx[CoordW] ? MagW'(-dx) : MagW'(dx);
        a_item_reg.ay <= dy[CoordW] ? MagW'(-dy) : MagW'(dy);
        a_item_reg.az <= dz[CoordW] ? MagW'(-dz) : MagW'(dz);
        a_item_reg.clamp <= 1'b0;
        a_item_reg.lim <= limit_reg;
    end

    // Stage B: squares, sum and the clamp test.
    logic b_valid_reg;
    drc3_item_t b_item_reg;
    drc3_item_t b_item_next;
    logic [SqW-1:0] b_sum_reg;
    logic [SqW-1:0] sum_w;

    always_comb
    begin
        sum_w = SqW'(a_item_reg.ax * a_item_reg.ax) + SqW'(a_item_reg.ay * a_item_reg.ay)
              + SqW'(a_item_reg.az * a_item_reg.az);
        b_item_next       = a_item_reg;
        b_item_next.clamp = sum_w > SqW'(a_item_reg.lim * a_item_reg.lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_item_reg <= b_item_next;
        b_sum_reg  <= sum_w;
    end

    // Square root chain.
    logic              sv [RootW+1];
    logic [SqW-1:0]    sr [RootW+1];
    logic [RootW-1:0]  sq [RootW+1];
    drc3_item_t        si [RootW+1];

    assign sv[0] = b_valid_reg;
    assign sr[0] = b_sum_reg;
    assign sq[0] = '0;
    assign si[0] = b_item_reg;

    for (genvar g = 0; g < RootW; g++)
    begin : g_sqrt
        drc3_sqrt_cell u_cell (
            .clk(clk), .rst_n(rst_n), .bit_pos(6'(RootW-1-g)),
            .in_valid(sv[g]), .in_rem(sr[g]), .in_root(sq[g]), .in_item(si[g]),
            .out_valid(sv[g+1]), .out_rem(sr[g+1]), .out_root(sq[g+1]),
            .out_item(si[g+1])
        );
    end

    // Divide chain: quotient of |d|*radius by the root.
    logic              dv [DivSteps+1];
    logic [RootW-1:0]  dd [DivSteps+1];
    logic [NumW-1:0]   dr [DivSteps+1][3];
    logic [QuoW-1:0]   dq [DivSteps+1][3];
    drc3_item_t        di [DivSteps+1];
    logic [RootW-1:0]  root_fix;

    assign root_fix = (sq[RootW] == '0) ? RootW'(1) : sq[RootW];
    assign dv[0] = sv[RootW];
    assign dd[0] = root_fix;
    assign di[0] = si[RootW];
    assign dr[0][0] = NumW'(si[RootW].ax * si[RootW].lim);
    assign dr[0][1] = NumW'(si[RootW].ay * si[RootW].lim);
    assign dr[0][2] = NumW'(si[RootW].az * si[RootW].lim);
    assign dq[0][0] = '0;
    assign dq[0][1] = '0;
    assign dq[0][2] = '0;

    for (genvar g = 0; g < DivSteps; g++)
    begin : g_div
        drc3_div_cell u_cell (
            .clk(clk), .rst_n(rst_n), .bit_pos(7'(DivSteps-1-g)),
            .in_valid(dv[g]), .den(dd[g]), .in_rem(dr[g]), .in_quo(dq[g]),
            .in_item(di[g]),
            .out_valid(dv[g+1]), .out_den(dd[g+1]), .out_rem(dr[g+1]),
            .out_quo(dq[g+1]), .out_item(di[g+1])
        );
    end

    // Round half away, apply sign, saturate; an unclamped point passes through as moved.
    drc3_item_t fi;
    logic [RootW-1:0] fd;
    logic signed [CoordW+1:0] res [3];
    logic [QuoW-1:0] qr;
    logic signed [CoordW-1:0] oc [3];
    logic signed [CoordW-1:0] mc [3];
    logic signed [CoordW-1:0] sat [3];
    logic [NumW-1:0] rm;

    assign fi = di[DivSteps];
    assign fd = dd[DivSteps];
    assign oc[0] = fi.ox;
    assign oc[1] = fi.oy;
    assign oc[2] = fi.oz;
    assign mc[0] = fi.mx;
    assign mc[1] = fi.my;
    assign mc[2] = fi.mz;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rm = dr[DivSteps][k];
            qr = dq[DivSteps][k];
            if (rm >= NumW'(fd) - rm)
                qr = qr + QuoW'(1);
            if (mc[k] < oc[k])
                res[k] = (CoordW+2)'(oc[k]) - (CoordW+2)'(signed'({1'b0, qr[CoordW:0]}));
            else
                res[k] = (CoordW+2)'(oc[k]) + (CoordW+2)'(signed'({1'b0, qr[CoordW:0]}));
            if (res[k] > (CoordW+2)'(signed'({1'b0, {(CoordW-1){1'b1}}})))
                sat[k] = {1'b0, {(CoordW-1){1'b1}}};
            else if (res[k] < -(CoordW+2)'(signed'({1'b0, 1'b1, {(CoordW-1){1'b0}}})))
                sat[k] = {1'b1, {(CoordW-1){1'b0}}};
            else
                sat[k] = res[k][CoordW-1:0];
            if (!fi.clamp)
                sat[k] = mc[k];
        end
    end

    // Output register: hold each result for one cycle with done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= dv[DivSteps];
    end

    always_ff @(posedge clk)
    begin
        held_x      <= sat[0];
        held_y      <= sat[1];
        held_z      <= sat[2];
        was_clamped <= fi.clamp;
    end
endmodule
